@@ rtl/core/hsvi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvi_pkg
// Shared types, constants and sector decode for the HSV to RGB pipeline.
// ----------------------------------------------------------------------------
package hsvi_pkg;

  typedef logic [7:0]  chan_t;
  typedef logic [10:0] hue_t;
  typedef logic [15:0] sv_t;
  typedef logic [23:0] prod_t;
  typedef logic [2:0]  sector_t;

  // Per-channel distance from full scale, (255 - c)
  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } dist_t;

  localparam chan_t FULL_SCALE = 8'hFF;
  localparam int unsigned FULL_SQ = 65025;

  // ceil(t / 65025) = ((t + 65024) * RECIP_M) >> RECIP_SHIFT, exact for t < 2^24
  localparam prod_t       CEIL_BIAS   = prod_t'(FULL_SQ - 1);
  localparam int unsigned RECIP_SHIFT = 40;
  localparam logic [24:0] RECIP_M     = 25'd16909061;
  localparam int unsigned PROD_W      = $bits(prod_t) + $bits(RECIP_M);

  localparam sector_t SEC_RED_GRN  = 3'd0;
  localparam sector_t SEC_GRN_RED  = 3'd1;
  localparam sector_t SEC_GRN_BLU  = 3'd2;
  localparam sector_t SEC_BLU_GRN  = 3'd3;
  localparam sector_t SEC_BLU_RED  = 3'd4;
  localparam sector_t SEC_RED_BLU  = 3'd5;
  localparam sector_t SEC_WRAP_EVN = 3'd6;
  localparam sector_t SEC_WRAP_ODD = 3'd7;

  function automatic dist_t sector_dist(input hue_t hue);
    sector_t sec;
    chan_t   pos;
    chan_t   dr;
    dist_t   d;
    sec = hue[10:8];
    pos = hue[7:0];
    // distance of the ramp channel; odd sectors run downwards
    dr  = sec[0] ? pos : chan_t'(FULL_SCALE - pos);
    case (sec) inside
      SEC_RED_GRN, SEC_WRAP_EVN: d = '{r: 8'd0,       g: dr,         b: FULL_SCALE};
      SEC_GRN_RED, SEC_WRAP_ODD: d = '{r: dr,         g: 8'd0,       b: FULL_SCALE};
      SEC_GRN_BLU:               d = '{r: FULL_SCALE, g: 8'd0,       b: dr};
      SEC_BLU_GRN:               d = '{r: FULL_SCALE, g: dr,         b: 8'd0};
      SEC_BLU_RED:               d = '{r: dr,         g: FULL_SCALE, b: 8'd0};
      default:                   d = '{r: 8'd0,       g: FULL_SCALE, b: dr};
    endcase
    return d;
  endfunction

endpackage

@@ rtl/core/hsv_to_rgb_integer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_integer
// Pipelined 8-bit HSV to RGB colour conversion.
//
// Input channel in_valid/in_ready carries hue (0..1535, six sectors of 256),
// saturation and brightness. Output channel out_valid/out_ready carries red,
// green and blue. One result item per input item, in order.
// Each accepted item is registered through sector decode and s*v, the
// (255-c)*s*v products, the reciprocal multiply for the divide by 65025,
// and the subtraction from brightness into the output register.
// Throughput is one item per clock while out_ready stays high. Each stage
// holds its item when it is full and the next one cannot take it, so a
// stall on out_ready backs up stage by stage and bubbles are squeezed out.
// Synchronous active-low reset empties the pipeline; data is not cleared.
// ----------------------------------------------------------------------------
module hsv_to_rgb_integer
  import hsvi_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  hue_t  in_hue,
  input  chan_t in_saturation,
  input  chan_t in_brightness,
  output logic  out_valid,
  input  logic  out_ready,
  output chan_t out_red,
  output chan_t out_green,
  output chan_t out_blue
);

  logic  s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic  s1_valid_nxt, s2_valid_nxt, s3_valid_nxt, out_valid_nxt;
  logic  s1_rdy, s2_rdy, s3_rdy, out_rdy;

  sv_t   s1_sv_r;
  dist_t s1_d_r;
  chan_t s1_v_r;

  prod_t s2_tr_r, s2_tg_r, s2_tb_r;
  chan_t s2_v_r;

  chan_t s3_qr_r, s3_qg_r, s3_qb_r;
  chan_t s3_v_r;

  chan_t out_red_r, out_green_r, out_blue_r;

  assign out_rdy = !out_valid_r || out_ready;
  assign s3_rdy  = !s3_valid_r  || out_rdy;
  assign s2_rdy  = !s2_valid_r  || s3_rdy;
  assign s1_rdy  = !s1_valid_r  || s2_rdy;

  assign s1_valid_nxt  = s1_rdy  ? in_valid   : s1_valid_r;
  assign s2_valid_nxt  = s2_rdy  ? s1_valid_r : s2_valid_r;
  assign s3_valid_nxt  = s3_rdy  ? s2_valid_r : s3_valid_r;
  assign out_valid_nxt = out_rdy ? s3_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      s3_valid_r  <= s3_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // stage 1: sector decode, s*v
  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_sv_r <= sv_t'(in_saturation) * sv_t'(in_brightness);
      s1_d_r  <= sector_dist(in_hue);
      s1_v_r  <= in_brightness;
    end
  end

  // stage 2: (255-c)*s*v plus ceiling bias
  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_tr_r <= prod_t'(s1_sv_r) * prod_t'(s1_d_r.r) + CEIL_BIAS;
      s2_tg_r <= prod_t'(s1_sv_r) * prod_t'(s1_d_r.g) + CEIL_BIAS;
      s2_tb_r <= prod_t'(s1_sv_r) * prod_t'(s1_d_r.b) + CEIL_BIAS;
      s2_v_r  <= s1_v_r;
    end
  end

  // stage 3: divide by 65025
  hsvi_div u_div_r (.clk(clk), .en(s3_rdy), .t_biased(s2_tr_r), .q_r(s3_qr_r));
  hsvi_div u_div_g (.clk(clk), .en(s3_rdy), .t_biased(s2_tg_r), .q_r(s3_qg_r));
  hsvi_div u_div_b (.clk(clk), .en(s3_rdy), .t_biased(s2_tb_r), .q_r(s3_qb_r));

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      s3_v_r <= s2_v_r;
    end
  end

  // output stage: v - ceil(v*s*(255-c)/65025)
  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_red_r   <= s3_v_r - s3_qr_r;
      out_green_r <= s3_v_r - s3_qg_r;
      out_blue_r  <= s3_v_r - s3_qb_r;
    end
  end

  assign in_ready  = s1_rdy;
  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  a_enter_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("accepted item did not enter stage 1");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with stage 1 empty");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (s3_qr_r <= s3_v_r) && (s3_qg_r <= s3_v_r) && (s3_qb_r <= s3_v_r))
    else $error("channel reduction exceeds brightness");

  a_max_chan: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (s3_qr_r == 8'd0) || (s3_qg_r == 8'd0) || (s3_qb_r == 8'd0))
    else $error("no channel at full brightness");

endmodule

@@ rtl/core/hsvi_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvi_div
// Registered division of a biased 24-bit product by 65025 (reciprocal form), giving the ceiling.
// ----------------------------------------------------------------------------
module hsvi_div
  import hsvi_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  prod_t t_biased,
  output chan_t q_r
);

  logic [PROD_W-1:0] prod;
  chan_t             q_nxt;

  assign prod  = PROD_W'(t_biased) * PROD_W'(RECIP_M);
  assign q_nxt = prod[RECIP_SHIFT +: $bits(chan_t)];

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

@@ bench/hsv_rgb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_rgb_checker
// Watches both channels of the HSV to RGB converter. On every accepted input
// item it computes the colour the block should give and queues it. Each
// accepted result is compared field by field with the oldest queued colour.
// ----------------------------------------------------------------------------
module hsv_rgb_checker
  import hsvi_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_ready,
  input  hue_t  in_hue,
  input  chan_t in_saturation,
  input  chan_t in_brightness,
  input  logic  out_valid,
  input  logic  out_ready,
  input  chan_t out_red,
  input  chan_t out_green,
  input  chan_t out_blue,
  output int    error_count,
  output int    due_count,
  output int    checked_count
);

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_px_t;

  rgb_px_t rgb_due[$];
  rgb_px_t want;

  function automatic chan_t scale_chan(input int unsigned c, input int unsigned sv,
                                       input int unsigned offs);
    int unsigned q;
    q = (c * sv + offs) / FULL_SQ;
    return chan_t'(q);
  endfunction

  function automatic rgb_px_t predict_rgb(input hue_t hue, input chan_t sat,
                                          input chan_t val);
    sector_t     sec;
    int unsigned ramp;
    int unsigned full;
    int unsigned cr;
    int unsigned cg;
    int unsigned cb;
    int unsigned sv;
    int unsigned offs;
    rgb_px_t     px;
    full = FULL_SCALE;
    sec  = hue[10:8];
    ramp = sec[0] ? full - hue[7:0] : hue[7:0];
    if (sec >= SEC_WRAP_EVN) sec = sec - 3'd6;
    case (sec)
      SEC_RED_GRN: begin cr = full; cg = ramp; cb = 0;    end
      SEC_GRN_RED: begin cr = ramp; cg = full; cb = 0;    end
      SEC_GRN_BLU: begin cr = 0;    cg = full; cb = ramp; end
      SEC_BLU_GRN: begin cr = 0;    cg = ramp; cb = full; end
      SEC_BLU_RED: begin cr = ramp; cg = 0;    cb = full; end
      default:     begin cr = full; cg = 0;    cb = ramp; end
    endcase
    sv   = sat * val;
    offs = val * FULL_SQ - sv * full;
    px.red   = scale_chan(cr, sv, offs);
    px.green = scale_chan(cg, sv, offs);
    px.blue  = scale_chan(cb, sv, offs);
    return px;
  endfunction

  task automatic compare_chan(input string name, input chan_t exp_v, input chan_t act_v);
    if (exp_v !== act_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  initial begin
    error_count   = 0;
    due_count     = 0;
    checked_count = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (rgb_due.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, got r=%0d g=%0d b=%0d",
                   $time, out_red, out_green, out_blue);
        end else begin
          want = rgb_due.pop_front();
          checked_count++;
          compare_chan("red", want.red, out_red);
          compare_chan("green", want.green, out_green);
          compare_chan("blue", want.blue, out_blue);
        end
      end
      if (in_valid && in_ready)
        rgb_due.push_back(predict_rgb(in_hue, in_saturation, in_brightness));
      due_count = rgb_due.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the HSV to RGB converter. Directed pixels cover
// every sector edge, wrapped hues and the saturation and brightness extremes;
// random pixels follow with bursty gaps and output stalls, one long stall
// that backs the pipeline up, and one pause that lets it drain.
// ----------------------------------------------------------------------------
module testbench;
  import hsvi_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 450;
  localparam int LONG_HOLD = 60;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  hue_t  in_hue;
  chan_t in_saturation;
  chan_t in_brightness;
  logic  out_valid;
  logic  out_ready;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;

  int error_count;
  int due_count;
  int checked_count;
  int items_sent;
  int gap_pct;
  int stall_pct;
  bit hold_long;
  int cycle_cnt;

  hsv_to_rgb_integer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  hsv_rgb_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .error_count   (error_count),
    .due_count     (due_count),
    .checked_count (checked_count)
  );

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_hue        = '0;
    in_saturation = '0;
    in_brightness = '0;
    out_ready     = 1'b0;
    gap_pct       = 0;
    stall_pct     = 0;
    hold_long     = 1'b0;
    items_sent    = 0;
  end

  always #5 clk = ~clk;

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("testbench: errors");
    $finish;
  end

  // result side: random stall bursts, plus one long hold when asked
  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_long = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(input hue_t h, input chan_t s, input chan_t v);
    int gap;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_hue        <= h;
    in_saturation <= s;
    in_brightness <= v;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  function automatic chan_t pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic hue_t pick_hue();
    int k;
    k = $urandom_range(0, 99);
    if (k < 5) return hue_t'($urandom_range(1536, 2047));
    if (k < 17) return {sector_t'($urandom_range(0, 5)), ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
    return hue_t'($urandom_range(0, 1535));
  endfunction

  hue_t edge_hue [16] = '{11'd0, 11'd255, 11'd256, 11'd511, 11'd512, 11'd767,
                          11'd768, 11'd1023, 11'd1024, 11'd1279, 11'd1280, 11'd1535,
                          11'd1536, 11'd1791, 11'd1792, 11'd2047};

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // pure colours at every sector edge, wrapped sectors included
    foreach (edge_hue[i]) send_pixel(edge_hue[i], 8'd255, 8'd255);
    // grey, black and the corners of saturation and brightness
    send_pixel(11'd384, 8'd0, 8'd255);
    send_pixel(11'd384, 8'd255, 8'd0);
    send_pixel(11'd1200, 8'd0, 8'd0);
    send_pixel(11'd700, 8'd1, 8'd1);
    send_pixel(11'd900, 8'd255, 8'd1);
    send_pixel(11'd1400, 8'd1, 8'd255);
    send_pixel(11'd1000, 8'd254, 8'd254);
    send_pixel(11'd1900, 8'd128, 8'd127);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      if (i == 100) begin
        gap_pct   = 0;
        hold_long = 1'b1;
      end
      if (i == 200) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait (due_count == 0);
      end
      if (i >= 380) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      send_pixel(pick_hue(), pick_level(), pick_level());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (due_count == 0);
    repeat (12) @(posedge clk);

    $display("summary: %0d pixels sent, %0d colours checked", items_sent, checked_count);
    $display("summary: all sectors and wrapped hues, level extremes, long stall and drain");
    if (error_count == 0 && due_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
